FILE: hdl/setc_pkg.sv
`default_nettype none
package setc_pkg;

	// Queue between the decode front and the tile back end
	localparam int unsigned QUEUE_DEPTH = 2;

	// Field positions in the attribute word
	localparam int unsigned ATTR_SMALL_BIT = 11;
	localparam int unsigned ATTR_FLIPX_BIT = 14;
	localparam int unsigned ATTR_FLIPY_BIT = 15;

	localparam logic [7:0] Y_ORIGIN = 8'd240;
	localparam logic [9:0] SCREEN_X_SHIFT = 10'd15;

	// Register map (byte address bit 2 selects the register slot)
	localparam logic REG_PRIORITY_PASS = 1'b0;

	// One decoded sprite waiting for tile expansion
	typedef struct packed {
		logic [15:0] code;
		logic [5:0]  color;
		logic        flip_x;
		logic        flip_y;
		logic [9:0]  base_x;
		logic [7:0]  base_y;
		logic        is_8x8;
	} sprite_t;

endpackage
`default_nettype wire

FILE: hdl/sprite_entry_to_tile_commands_core.sv
// The first tile command of an accepted entry passes the queue write, the
// back-end load and the output register before it shows on the result ports.
// Throughput: one tile command per cycle, so an 8x8 sprite yields one command
// and a 16x16 sprite four from the back-end tile counter; an entry outside the
// priority pass yields none. The receiver cannot stall.
// Reset (arst_n low, asynchronous) empties the queue and clears priority_pass.
`default_nettype none
module sprite_entry_to_tile_commands_core
	import setc_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] attr_y_word,
	input  wire logic [15:0] color_x_word,
	input  wire logic [15:0] code_word,
	// result channel
	output logic             strobe,
	output logic [15:0]      tile_code,
	output logic [5:0]       tile_color,
	output logic             mirror_x,
	output logic             mirror_y,
	output logic signed [9:0] screen_x,
	output logic [8:0]       screen_y,
	output logic             last_tile,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [1:0] priority_pass_q;
	logic       take;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;
	sprite_t    front_sprite;
	sprite_t    head;

	// Configuration: zero-wait-state register port, one register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priority_pass_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_PRIORITY_PASS) begin
			priority_pass_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PRIORITY_PASS) ? {30'd0, priority_pass_q} : '0;

	// Hold new commands off only while the queue is full; the back end keeps
	// draining it independently, so a transaction can land every cycle while it is not full.
	assign busy = full;
	assign take = start && !busy;

	// Front: filter by priority pass and pre-compute the sprite's base values
	setc_front u_front (
		.take          (take),
		.attr_y_word   (attr_y_word),
		.color_x_word  (color_x_word),
		.code_word     (code_word),
		.priority_pass (priority_pass_q),
		.push          (push),
		.sprite        (front_sprite)
	);

	// Queue decouples decode from tile expansion
	setc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_sprite),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	// Back: walk the quadrants in row-major order, one command per cycle
	setc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.strobe     (strobe),
		.tile_code  (tile_code),
		.tile_color (tile_color),
		.mirror_x   (mirror_x),
		.mirror_y   (mirror_y),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.last_tile  (last_tile)
	);

endmodule
`default_nettype wire

FILE: hdl/setc_front.sv
`default_nettype none
module setc_front
	import setc_pkg::*;
(
	input  wire logic        take,
	input  wire logic [15:0] attr_y_word,
	input  wire logic [15:0] color_x_word,
	input  wire logic [15:0] code_word,
	input  wire logic [1:0]  priority_pass,
	output logic             push,
	output sprite_t          sprite
);

	logic is_8x8;

	assign is_8x8 = attr_y_word[ATTR_SMALL_BIT];

	// Drop entries outside the current priority pass
	assign push = take && (attr_y_word[13:12] == priority_pass);

	always_comb begin
		sprite.is_8x8 = is_8x8;
		sprite.code   = is_8x8 ? code_word : {code_word[15:2], 2'b00};
		sprite.color  = color_x_word[14:9];
		sprite.flip_x = attr_y_word[ATTR_FLIPX_BIT];
		sprite.flip_y = attr_y_word[ATTR_FLIPY_BIT];
		sprite.base_x = {1'b0, color_x_word[8:0]} - SCREEN_X_SHIFT;
		sprite.base_y = Y_ORIGIN - attr_y_word[7:0];
	end

endmodule
`default_nettype wire

FILE: hdl/setc_queue.sv
`default_nettype none
module setc_queue
	import setc_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire sprite_t push_data,
	input  wire logic    pop,
	output sprite_t      head,
	output logic         empty,
	output logic         full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sprite_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/setc_back.sv
`default_nettype none
module setc_back
	import setc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sprite_t     head,
	input  wire logic        empty,
	output logic             pop,
	output logic             strobe,
	output logic [15:0]      tile_code,
	output logic [5:0]       tile_color,
	output logic             mirror_x,
	output logic             mirror_y,
	output logic signed [9:0] screen_x,
	output logic [8:0]       screen_y,
	output logic             last_tile
);

	sprite_t     cur_q;
	logic        active_q;
	logic [1:0]  idx_q;      // bit 1 row, bit 0 column
	logic        col, row, ecol, erow;
	logic        last_now;
	logic        advance;

	assign col  = idx_q[0];
	assign row  = idx_q[1];
	// Mirror the quadrant selection; an 8x8 sprite has no offset
	assign ecol = !cur_q.is_8x8 && (col ^ cur_q.flip_x);
	assign erow = !cur_q.is_8x8 && (row ^ cur_q.flip_y);

	assign last_now = active_q && (cur_q.is_8x8 || idx_q == 2'd3);
	assign advance  = !active_q || last_now;
	assign pop      = advance && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= active_q;
			if (advance) begin
				active_q <= !empty;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		tile_code  <= cur_q.code + {14'd0, ecol, erow};
		tile_color <= cur_q.color;
		mirror_x   <= cur_q.flip_x;
		mirror_y   <= cur_q.flip_y;
		screen_x   <= cur_q.base_x + {6'd0, col, 3'd0};
		screen_y   <= {1'b0, cur_q.base_y} + {5'd0, row, 3'd0};
		last_tile  <= cur_q.is_8x8 || idx_q == 2'd3;
	end

endmodule
`default_nettype wire
